>>> hdl/sitda_pkg.sv
package sitda_pkg;

    localparam int VAL_W       = 32;
    localparam int DIG_W       = 4;
    localparam int MAX_DIGITS  = 10;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 35;
    localparam int QUOT_W      = 2 * VAL_W - RECIP_SHIFT;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [VAL_W-1:0] RECIP      = 32'hCCCC_CCCD;
    localparam logic [7:0]       CHAR_ZERO  = 8'h30;
    localparam logic [7:0]       CHAR_MINUS = 8'h2D;

    typedef struct packed {
        logic             neg;
        logic [VAL_W-1:0] mag;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_SIGN,
        ST_EMIT
    } t_state;

endpackage

>>> hdl/signed_int_to_decimal_ascii_unit.sv
// Channel   Handshake              Payload
// input     start high, busy low   i_value (32-bit signed)
// result    o_strobe, one cycle    o_ascii_char (8-bit), o_last_char
//
// An accepted beat enters a two-entry queue and the converter takes it
// once it is idle. Digits come out least significant first through one
// shared reciprocal multiplier, a multiply step and a remainder step per
// digit, then leave most significant first at one character per cycle,
// after a minus sign for a negative number.
// Reset is synchronous and empties the queue. The receiver cannot stall.
module signed_int_to_decimal_ascii_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [sitda_pkg::VAL_W-1:0] i_value,
    output logic                        o_strobe,
    output logic [7:0]                  o_ascii_char,
    output logic                        o_last_char
);
    import sitda_pkg::*;

    logic  w_push;
    logic  w_pop;
    logic  w_empty;
    logic  w_full;
    t_item w_in_item;
    t_item w_q_item;

    assign busy = w_full;

    sitda_front u_front (
        .i_start (start),
        .i_value (i_value),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_item  (w_in_item)
    );

    sitda_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_item  (w_q_item),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    sitda_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (w_q_item),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

>>> hdl/sitda_front.sv
module sitda_front (
    input  logic                       i_start,
    input  logic [sitda_pkg::VAL_W-1:0] i_value,
    input  logic                       i_full,
    output logic                       o_push,
    output sitda_pkg::t_item           o_item
);
    import sitda_pkg::*;

    logic             w_neg;
    logic [VAL_W-1:0] w_mag;

    assign w_neg  = i_value[VAL_W-1];
    assign w_mag  = w_neg ? (~i_value + VAL_W'(1)) : i_value;
    assign o_push = i_start && !i_full;
    assign o_item = '{neg: w_neg, mag: w_mag};

endmodule

>>> hdl/sitda_fifo.sv
module sitda_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sitda_pkg::t_item i_item,
    input  logic             i_pop,
    output sitda_pkg::t_item o_item,
    output logic             o_empty,
    output logic             o_full
);
    import sitda_pkg::*;

    t_item              r_mem [QDEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QCNT_W-1:0]  r_count;
    logic               w_push;
    logic               w_pop;

    assign o_empty = (r_count == QCNT_W'(0));
    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

>>> hdl/sitda_back.sv
module sitda_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sitda_pkg::t_item i_item,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_strobe,
    output logic [7:0]       o_ascii_char,
    output logic             o_last_char
);
    import sitda_pkg::*;

    t_state              r_state;
    t_state              n_state;
    logic                r_neg;
    logic [VAL_W-1:0]    r_mag;
    logic [QUOT_W-1:0]   r_quot;
    logic [DIG_W-1:0]    r_digits [MAX_DIGITS];
    logic [CNT_W-1:0]    r_nd;
    logic [CNT_W-1:0]    r_idx;
    logic                r_strobe;
    logic                n_strobe;
    logic [7:0]          r_char;
    logic [7:0]          n_char;
    logic                r_last;
    logic                n_last;

    logic [2*VAL_W-1:0]  w_prod;
    logic [DIG_W-1:0]    w_q10_lo;
    logic [DIG_W-1:0]    w_rem;
    logic [CNT_W-1:0]    w_rd_idx;

    assign w_prod   = (2*VAL_W)'(r_mag) * (2*VAL_W)'(RECIP);
    assign w_q10_lo = {r_quot[0], 3'b000} + {r_quot[2:0], 1'b0};
    assign w_rem    = r_mag[DIG_W-1:0] - w_q10_lo;
    assign w_rd_idx = r_idx - CNT_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_REM;
            end
            ST_REM: begin
                if (r_quot == '0) begin
                    n_state = r_neg ? ST_SIGN : ST_EMIT;
                end else begin
                    n_state = ST_MUL;
                end
            end
            ST_SIGN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (r_idx == CNT_W'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop    = 1'b0;
        n_strobe = 1'b0;
        n_char   = CHAR_ZERO;
        n_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop = !i_empty;
            end
            ST_SIGN: begin
                n_strobe = 1'b1;
                n_char   = CHAR_MINUS;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_char   = CHAR_ZERO + {4'b0000, r_digits[w_rd_idx]};
                n_last   = (r_idx == CNT_W'(1));
            end
            default: begin
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_neg <= i_item.neg;
                r_mag <= i_item.mag;
                r_nd  <= '0;
            end
            ST_MUL: begin
                r_quot <= w_prod[2*VAL_W-1:RECIP_SHIFT];
            end
            ST_REM: begin
                r_digits[r_nd] <= w_rem;
                r_nd           <= r_nd + CNT_W'(1);
                r_mag          <= VAL_W'(r_quot);
                r_idx          <= r_nd + CNT_W'(1);
            end
            ST_EMIT: begin
                r_idx <= w_rd_idx;
            end
            default: begin
                r_idx <= r_idx;
            end
        endcase
        r_char <= n_char;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    assign o_strobe     = r_strobe;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

>>> hdl/sitda_checker.sv
module sitda_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_strobe,
    input logic [7:0] o_ascii_char,
    input logic       o_last_char
);
    import sitda_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("Result beat directly after reset.");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_char) |=> o_strobe)
        else $error("Gap inside a run of characters.");

    a_char_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_ascii_char == CHAR_MINUS && !o_last_char)
                      || (o_ascii_char >= CHAR_ZERO
                          && o_ascii_char <= CHAR_ZERO + 8'd9)))
        else $error("Illegal character on the result port.");

    a_sign_then_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_ascii_char == CHAR_MINUS)
            |=> (o_strobe && o_ascii_char != CHAR_MINUS))
        else $error("Sign not followed by a digit.");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |=> !o_strobe)
        else $error("Result beat directly after the final character.");

endmodule

bind signed_int_to_decimal_ascii_unit sitda_checker u_sitda_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_strobe     (o_strobe),
    .o_ascii_char (o_ascii_char),
    .o_last_char  (o_last_char)
);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import sitda_pkg::*;

    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 4000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_ascii_beat;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [VAL_W-1:0]    i_value = '0;
    logic                o_strobe;
    logic [7:0]          o_ascii_char;
    logic                o_last_char;

    t_ascii_beat expected_text[$];
    t_ascii_beat want;
    int          sender_gap_pct = 0;
    int          numbers_sent   = 0;
    int          chars_checked  = 0;
    int          errors         = 0;
    int          quiet_cycles   = 0;

    logic [VAL_W-1:0] corner_values [20] = '{
        32'd0, 32'd1, -32'd1, 32'd9, 32'd10, -32'd10, 32'd100, -32'd7,
        32'd2147483647, 32'h8000_0000, -32'd2147483647, 32'd1000000000,
        -32'd1000000000, 32'd999999999, -32'd999999999, 32'd123456789,
        32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000, 32'd4294967286
    };

    signed_int_to_decimal_ascii_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .o_strobe     (o_strobe),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void predict_decimal_text(input logic [VAL_W-1:0] value);
        logic             neg;
        logic [VAL_W-1:0] mag;
        logic [3:0]       digits [MAX_DIGITS];
        int               n;
        t_ascii_beat      beat;
        neg = value[VAL_W-1];
        mag = neg ? (~value + 1'b1) : value;
        n   = 0;
        do begin
            digits[n] = 4'(mag % 10);
            mag       = mag / 10;
            n++;
        end while (mag != 0);
        if (neg) begin
            beat.ch   = CHAR_MINUS;
            beat.last = 1'b0;
            expected_text.push_back(beat);
        end
        for (int k = n - 1; k >= 0; k--) begin
            beat.ch   = CHAR_ZERO + 8'(digits[k]);
            beat.last = (k == 0);
            expected_text.push_back(beat);
        end
    endfunction

    // A beat is taken at an edge where start is high and busy is low.
    task automatic send_value(input logic [VAL_W-1:0] value);
        if ($urandom_range(99) < sender_gap_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_gap_pct);
        end
        start   <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (busy);
        predict_decimal_text(value);
        numbers_sent++;
    endtask

    task automatic send_random_value();
        int unsigned      ndig;
        int unsigned      lo;
        int unsigned      hi;
        logic [VAL_W-1:0] value;
        if ($urandom_range(1)) begin
            value = $urandom();
        end else begin
            ndig = $urandom_range(MAX_DIGITS, 1);
            lo   = 1;
            repeat (ndig - 1) lo = lo * 10;
            hi = (ndig == MAX_DIGITS) ? 32'd2147483647 : lo * 10 - 1;
            if (ndig == 1) begin
                lo = 0;
            end
            value = $urandom_range(hi, lo);
            if ($urandom_range(1)) begin
                value = -value;
            end
        end
        send_value(value);
    endtask

    task automatic wait_until_drained();
        start <= 1'b0;
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_corner_values();
        sender_gap_pct = 0;
        foreach (corner_values[i]) begin
            send_value(corner_values[i]);
        end
        wait_until_drained();
    endtask

    task automatic test_back_to_back();
        sender_gap_pct = 0;
        repeat (150) send_random_value();
    endtask

    task automatic test_sparse_sender();
        sender_gap_pct = 71;
        repeat (150) send_random_value();
    endtask

    task automatic test_light_gaps();
        sender_gap_pct = 29;
        repeat (130) send_random_value();
    endtask

    task automatic test_drain_pauses();
        sender_gap_pct = 0;
        wait_until_drained();
        repeat (12) begin
            repeat ($urandom_range(5, 1)) send_random_value();
            wait_until_drained();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (expected_text.size() == 0) begin
                $display("%0t: unexpected character, expected none, actual %h last %b",
                         $time, o_ascii_char, o_last_char);
                errors++;
            end else begin
                want = expected_text.pop_front();
                if (o_ascii_char !== want.ch) begin
                    $display("%0t: ascii_char mismatch, expected %h, actual %h",
                             $time, want.ch, o_ascii_char);
                    errors++;
                end
                if (o_last_char !== want.last) begin
                    $display("%0t: last_char mismatch, expected %b, actual %b",
                             $time, want.last, o_last_char);
                    errors++;
                end
                chars_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout after %0d cycles without a beat.", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corner_values();
        test_back_to_back();
        test_sparse_sender();
        test_light_gaps();
        test_drain_pauses();
        wait_until_drained();
        $display("Converted %0d numbers into %0d characters, from corner values",
                 numbers_sent, chars_checked);
        $display("to random values of every length, with sender gaps of 0, 29 and 71 percent.");
        if (errors == 0 && expected_text.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
